FILE: src/sisk_pkg.sv
// ----------------------------------------------------------------------------
// sisk_pkg
// Shared constants and types for the stable insertion sorter.
// ----------------------------------------------------------------------------
package sisk_pkg;

   localparam int CAPACITY_DEF  = 64;   // default number of stored records
   localparam int KEY_WIDTH_DEF = 16;   // default compared key width
   localparam int ID_WIDTH      = 16;   // record identifier width
   localparam int PORT_KEY_W    = 16;   // key width on the channels
   localparam int QUEUE_DEPTH   = 4;    // front-to-back queue entries

   // head-of-queue status seen by the back end
   typedef struct packed {
      logic valid;   // an entry is waiting
      logic last;    // entry closes the set
   } q_status_type;

endpackage

FILE: src/sisk_req_if.sv
// ----------------------------------------------------------------------------
// sisk_req_if
// Record channel: valid/ready handshake with id, key and last flag.
// ----------------------------------------------------------------------------
interface sisk_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] record_id;
   logic [15:0] sort_key;
   logic        last_record;

   modport source (output valid, output record_id, output sort_key,
                   output last_record, input ready);
   modport sink   (input valid, input record_id, input sort_key,
                   input last_record, output ready);
endinterface

FILE: src/sisk_rsp_if.sv
// ----------------------------------------------------------------------------
// sisk_rsp_if
// Sorted result channel: valid/ready handshake with id, key and flags.
// ----------------------------------------------------------------------------
interface sisk_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_record_id;
   logic [15:0] out_sort_key;
   logic        out_last;
   logic        overflow;

   modport source (output valid, output out_record_id, output out_sort_key,
                   output out_last, output overflow, input ready);
   modport sink   (input valid, input out_record_id, input out_sort_key,
                   input out_last, input overflow, output ready);
endinterface

FILE: src/sisk_ram.sv
// ----------------------------------------------------------------------------
// sisk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sisk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/sisk_front.sv
// ----------------------------------------------------------------------------
// sisk_front
// Accepts record transactions, trims the key, and queues them for the back end.
// ----------------------------------------------------------------------------
module sisk_front #(
   parameter int KEY_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   sisk_req_if.sink               req_if,
   output sisk_pkg::q_status_type q_status,
   output logic [15:0]            q_id,
   output logic [KEY_WIDTH-1:0]   q_key,
   input  logic                   q_pop
);
   import sisk_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [ID_WIDTH-1:0]  ids_ff  [QUEUE_DEPTH];
   logic [KEY_WIDTH-1:0] keys_ff [QUEUE_DEPTH];
   logic                 last_ff [QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          push;
   logic          pop;

   assign req_if.ready = (fill_ff != CW'(QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign pop          = q_pop && (fill_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // payload slots, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         ids_ff[wr_ptr_ff]  <= req_if.record_id;
         keys_ff[wr_ptr_ff] <= KEY_WIDTH'(req_if.sort_key);   // drop bits above KEY_WIDTH
         last_ff[wr_ptr_ff] <= req_if.last_record;
      end
   end

   assign q_status.valid = (fill_ff != '0);
   assign q_status.last  = last_ff[rd_ptr_ff];
   assign q_id           = ids_ff[rd_ptr_ff];
   assign q_key          = keys_ff[rd_ptr_ff];

endmodule

FILE: src/sisk_back.sv
// ----------------------------------------------------------------------------
// sisk_back
// Insertion engine over the record RAM plus the sorted-run emitter.
// ----------------------------------------------------------------------------
module sisk_back #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sisk_pkg::q_status_type q_status,
   input  logic [15:0]            q_id,
   input  logic [KEY_WIDTH-1:0]   q_key,
   output logic                   q_pop,
   sisk_rsp_if.source             rsp_if
);
   import sisk_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = ID_WIDTH + KEY_WIDTH;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_SHIFT   = 2'd1;
   localparam logic [1:0] S_EMIT_RD = 2'd2;
   localparam logic [1:0] S_EMIT_LD = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 dropped_ff, dropped_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [ID_WIDTH-1:0]  id_ff, id_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 last_ff, last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_id_ff, rsp_id_in;
   logic [15:0]          rsp_key_ff, rsp_key_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [RW-1:0]        wr_data, rd_data;
   logic [KEY_WIDTH-1:0] rd_key;
   logic [ID_WIDTH-1:0]  rd_id;
   logic [CW-1:0]        count_m1, pos_m1, pos_m2, idx_p1;
   logic                 out_free;
   logic                 emit_load;
   logic                 emit_end;

   sisk_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_key   = rd_data[KEY_WIDTH-1:0];
   assign rd_id    = rd_data[RW-1 -: ID_WIDTH];
   assign count_m1 = count_ff - CW'(1);
   assign pos_m1   = pos_ff - CW'(1);
   assign pos_m2   = pos_ff - CW'(2);
   assign idx_p1   = CW'(idx_ff) + CW'(1);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign emit_load = (state_ff == S_EMIT_LD) && out_free;
   assign emit_end  = emit_load && (idx_p1 == count_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      id_in      = id_ff;
      key_in     = key_ff;
      last_in    = last_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = pos_ff[AW-1:0];
      wr_data    = {id_ff, key_ff};
      rd_en      = 1'b0;
      rd_addr    = count_m1[AW-1:0];

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_status.valid) begin
               q_pop   = 1'b1;
               id_in   = q_id;
               key_in  = q_key;
               last_in = q_status.last;
               idx_in  = '0;
               if (count_ff == CW'(CAPACITY)) begin
                  // store full: drop, but a closing record still flushes
                  dropped_in = 1'b1;
                  if (q_status.last) begin
                     state_in = S_EMIT_RD;
                  end
               end else begin
                  pos_in   = count_ff;
                  rd_en    = (count_ff != '0);
                  rd_addr  = count_m1[AW-1:0];
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // rd_data holds entry pos-1; strictly greater key moves up
            if ((pos_ff != '0) && (key_ff < rd_key)) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = rd_data;
               pos_in  = pos_m1;
               rd_en   = (pos_ff > CW'(1));
               rd_addr = pos_m2[AW-1:0];
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = {id_ff, key_ff};
               count_in = count_ff + CW'(1);
               state_in = last_ff ? S_EMIT_RD : S_IDLE;
            end
         end
         S_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = rd_id;
               rsp_key_in   = 16'(rd_key);
               rsp_last_in  = emit_end;
               rsp_ovf_in   = dropped_ff;
               if (emit_end) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      last_ff     <= last_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.out_record_id = rsp_id_ff;
   assign rsp_if.out_sort_key  = rsp_key_ff;
   assign rsp_if.out_last      = rsp_last_ff;
   assign rsp_if.overflow      = rsp_ovf_ff;

   // store never holds more than its capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("record count above capacity");

   // insertion point stays inside the occupied part of the store
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (pos_ff <= count_ff))
      else $error("insertion position beyond record count");

   // closing result empties the store and clears the overflow flag
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      emit_end |=> (count_ff == '0) && !dropped_ff && rsp_if.out_last)
      else $error("store not emptied after last result");

   // queue is only popped while the engine is free
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE) && q_status.valid)
      else $error("queue popped while engine busy");

   // a pending result is never overwritten before it is taken
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> rsp_valid_ff && $stable(rsp_id_ff))
      else $error("pending result lost");

endmodule

FILE: src/stable_insertion_sort_by_key.sv
// ----------------------------------------------------------------------------
// stable_insertion_sort_by_key
// Collects records and emits them sorted by key, stable on equal keys.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries one record per transaction (record_id, sort_key,
//    last_record). Key bits above KEY_WIDTH are ignored.
//  - Records land in a 4-entry queue, so req_if keeps taking transactions
//    while the insertion engine or the result channel is busy.
//  - Insertion walks down the record RAM one compare-and-move per cycle,
//    after a start in the idle state, and ends by writing the new record;
//    the single-port read of the record RAM sets this rate.
//  - A closing record (last_record set) is inserted, or dropped if the store
//    is full; then the whole store goes out on rsp_if lowest key first, each
//    result read and then registered; out_last marks the final one, overflow
//    is set on every result of a set in which any record found the store full.
//  - After the final result the store is empty and overflow is cleared.
//  - rsp_if has an output register; when it stalls, the result holds and
//    the emitter waits, while req_if still fills the queue.
//  - Synchronous reset empties queue and store and drops any pending result.
// ----------------------------------------------------------------------------
module stable_insertion_sort_by_key #(
   parameter int CAPACITY  = sisk_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = sisk_pkg::KEY_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sisk_req_if.sink    req_if,
   sisk_rsp_if.source  rsp_if
);
   import sisk_pkg::*;

   q_status_type         q_status;   // head of queue
   logic [ID_WIDTH-1:0]  q_id;
   logic [KEY_WIDTH-1:0] q_key;
   logic                 q_pop;

   // front: accept and trim records, queue them
   sisk_front #(.KEY_WIDTH(KEY_WIDTH)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_status(q_status),
      .q_id    (q_id),
      .q_key   (q_key),
      .q_pop   (q_pop)
   );

   // back: insertion into the sorted store, then run emission
   sisk_back #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_status(q_status),
      .q_id    (q_id),
      .q_key   (q_key),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

FILE: tb/sort_result_checker.sv
// ----------------------------------------------------------------------------
// sort_result_checker
// Watches both channels of the insertion sorter. It keeps a shadow copy of
// the sorted store, queues the sorted runs that each closing record releases,
// and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module sort_result_checker #(
   parameter int CAPACITY  = sisk_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = sisk_pkg::KEY_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   sisk_req_if  req_mon,
   sisk_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   results_checked,
   output int   sets_closed,
   output int   overflow_sets
);
   timeunit 1ns;
   timeprecision 1ps;
   import sisk_pkg::*;

   localparam int MAX_PRINTED = 20;

   typedef struct packed {
      logic [ID_WIDTH-1:0]   record_id;
      logic [PORT_KEY_W-1:0] sort_key;
      logic                  last;
      logic                  overflow;
   } sorted_rec_type;

   logic [ID_WIDTH-1:0]  shadow_ids  [CAPACITY];
   logic [KEY_WIDTH-1:0] shadow_keys [CAPACITY];
   int                   shadow_count;
   logic                 shadow_dropped;
   sorted_rec_type       sorted_q [$];

   int errors  = 0;
   int checked = 0;
   int sets    = 0;
   int ovf     = 0;
   int pending_r = 0;

   assign fail_count      = errors;
   assign pending         = pending_r;
   assign results_checked = checked;
   assign sets_closed     = sets;
   assign overflow_sets   = ovf;

   task automatic report_mismatch(input string msg);
      if (errors < MAX_PRINTED)
         $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
   endtask

   // insert one record into the shadow store; a closing record releases the run
   task automatic predict_record(input logic [ID_WIDTH-1:0] id,
                                 input logic [PORT_KEY_W-1:0] key_in,
                                 input logic last);
      logic [KEY_WIDTH-1:0] key;
      sorted_rec_type       rec;
      int                   pos;
      key = KEY_WIDTH'(key_in);
      if (shadow_count >= CAPACITY) begin
         shadow_dropped = 1'b1;
      end else begin
         pos = shadow_count;
         // only a strictly greater key moves up: equal keys keep arrival order
         while (pos > 0 && key < shadow_keys[pos-1]) begin
            shadow_keys[pos] = shadow_keys[pos-1];
            shadow_ids[pos]  = shadow_ids[pos-1];
            pos--;
         end
         shadow_keys[pos] = key;
         shadow_ids[pos]  = id;
         shadow_count++;
      end
      if (last) begin
         for (int k = 0; k < shadow_count; k++) begin
            rec.record_id = shadow_ids[k];
            rec.sort_key  = PORT_KEY_W'(shadow_keys[k]);
            rec.last      = (k == shadow_count - 1);
            rec.overflow  = shadow_dropped;
            sorted_q.push_back(rec);
         end
         sets++;
         if (shadow_dropped)
            ovf++;
         shadow_count   = 0;
         shadow_dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      sorted_rec_type want;
      if (reset) begin
         shadow_count   = 0;
         shadow_dropped = 1'b0;
         sorted_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (sorted_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result id=0x%0h key=0x%0h",
                                         rsp_mon.out_record_id, rsp_mon.out_sort_key));
            end else begin
               want = sorted_q.pop_front();
               checked++;
               if (rsp_mon.out_record_id !== want.record_id)
                  report_mismatch($sformatf("out_record_id got 0x%0h exp 0x%0h",
                                            rsp_mon.out_record_id, want.record_id));
               if (rsp_mon.out_sort_key !== want.sort_key)
                  report_mismatch($sformatf("out_sort_key got 0x%0h exp 0x%0h",
                                            rsp_mon.out_sort_key, want.sort_key));
               if (rsp_mon.out_last !== want.last)
                  report_mismatch($sformatf("out_last got %b exp %b",
                                            rsp_mon.out_last, want.last));
               if (rsp_mon.overflow !== want.overflow)
                  report_mismatch($sformatf("overflow got %b exp %b",
                                            rsp_mon.overflow, want.overflow));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_record(req_mon.record_id, req_mon.sort_key, req_mon.last_record);
      end
      pending_r <= sorted_q.size();
   end

endmodule

FILE: tb/stable_insertion_sort_by_key_tb.sv
// ----------------------------------------------------------------------------
// stable_insertion_sort_by_key_tb
// Drives record sets into the sorter and gives the verdict. Directed sets hit
// the key and id extremes, ties and worst-case shifting; random sets of mostly
// small size follow, with one overflowing set that fills the store. Both sides
// idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module stable_insertion_sort_by_key_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sisk_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
   localparam int LONG_HOLD     = 600;     // result-side hold-off, in cycles
   localparam int DRAIN_CYCLES  = 200;     // outlasts the insertion of one record
   localparam int SMALL_TARGET  = 16;      // random records in small sets
   localparam int LAST_FIXED    = 4;       // random sets up to here always run

   logic clock;
   logic reset;

   sisk_req_if req_ch ();
   sisk_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int results_checked;
   int sets_closed;
   int overflow_sets;

   int cycle_count     = 0;
   int rsp_hold_cycles = 0;   // nonzero: receiver's next stall uses this length
   int send_calm       = 0;   // cycles left in a no-gap stretch, per side
   int recv_calm       = 0;

   stable_insertion_sort_by_key #(
      .CAPACITY  (CAPACITY_DEF),
      .KEY_WIDTH (KEY_WIDTH_DEF)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   sort_result_checker #(
      .CAPACITY  (CAPACITY_DEF),
      .KEY_WIDTH (KEY_WIDTH_DEF)
   ) u_sort_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .sets_closed     (sets_closed),
      .overflow_sets   (overflow_sets)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("FAILURE");
      $finish;
   end

   // Idle cycles before one transaction, drawn at random, with occasional stretches of
   // back-to-back traffic so some phases see no gaps at all.
   function automatic int draw_gap(inout int calm_left);
      int g;
      if (calm_left > 0) begin
         calm_left--;
         g = 0;
      end else begin
         g = $urandom_range(0, 9);
         if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(10, 30);
      end
      return g;
   endfunction

   // One record transaction. valid drops only when a gap is drawn, so a
   // back-to-back record never sees valid lowered and raised in one step.
   task automatic send_record(input logic [ID_WIDTH-1:0] id,
                              input logic [PORT_KEY_W-1:0] key,
                              input logic last);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.record_id   <= id;
      req_ch.sort_key    <= key;
      req_ch.last_record <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Sender pause: drop valid and wait until every sorted result has come.
   // Waiting on the clock first lets the checker's count catch up with the last transaction.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Result side: per transaction a random stall, or the long hold-off when
   // the stimulus asks for one. During that hold the emitter sits on its
   // output register and the record queue fills behind it.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = draw_gap(recv_calm);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Stimulus
   initial begin
      int   small_items;
      int   set_idx;
      int   set_size;
      logic tie_mode;
      logic [PORT_KEY_W-1:0] key;

      req_ch.valid       <= 1'b0;
      req_ch.record_id   <= '0;
      req_ch.sort_key    <= '0;
      req_ch.last_record <= 1'b0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed sets ---
      // single record, closes immediately: one result, all zeros
      send_record(16'h0000, 16'h0000, 1'b1);

      // key/id extremes with duplicates at both ends; ties must keep order
      send_record(16'hFFFF, 16'hFFFF, 1'b0);
      send_record(16'h0001, 16'h0000, 1'b0);
      send_record(16'hAAAA, 16'hFFFF, 1'b0);
      send_record(16'h5555, 16'h0000, 1'b0);
      send_record(16'h0000, 16'h5555, 1'b0);
      send_record(16'h1234, 16'hAAAA, 1'b1);
      wait_drained();

      // all keys equal: output is arrival order
      send_record(16'h0010, 16'h0005, 1'b0);
      send_record(16'h0011, 16'h0005, 1'b0);
      send_record(16'h0012, 16'h0005, 1'b1);

      // strictly descending keys: every insert shifts the whole store
      for (int i = 0; i < 8; i++)
         send_record(16'h0020 + 16'(i), 16'(7 - i), (i == 7));

      // ascending keys: no shifting at all
      for (int i = 0; i < 4; i++)
         send_record(16'hFF00 + 16'(i), 16'h0100 + 16'(i), (i == 3));
      wait_drained();

      // --- random sets ---
      // Set 1 runs into a long result-side hold while the sender keeps going.
      // Set 3 fills the store and overflows: its 65th record and its closing
      // record are dropped. It does not count toward the small-set target.
      small_items = 0;
      set_idx     = 0;
      while (small_items < SMALL_TARGET || set_idx <= LAST_FIXED) begin
         if (set_idx == 1)
            rsp_hold_cycles = LONG_HOLD;
         if (set_idx == 3)
            set_size = CAPACITY_DEF + 2;
         else begin
            set_size = $urandom_range(1, 8);
            small_items += set_size;
         end
         tie_mode = $urandom_range(0, 1);
         for (int i = 0; i < set_size; i++) begin
            // narrow keys make ties frequent; wide keys toggle every bit
            key = tie_mode ? PORT_KEY_W'($urandom_range(0, 7))
                           : PORT_KEY_W'($urandom_range(0, 65535));
            send_record(ID_WIDTH'($urandom_range(0, 65535)), key, (i == set_size - 1));
         end
         if (set_idx == 4 || (set_idx > 2 && $urandom_range(0, 5) == 0))
            wait_drained();
         set_idx++;
      end

      // --- end of run ---
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d sorted results from %0d record sets, %0d of them with drops.",
               results_checked, sets_closed, overflow_sets);
      $display("Covered ties, extreme keys, full and overflowing store, random stalls.");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
